// ===== src/palette_linear_fade_engine_defines.svh =====
// Assertion macros shared by the fade engine RTL.
`ifndef PALETTE_LINEAR_FADE_ENGINE_DEFINES_SVH
`define PALETTE_LINEAR_FADE_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PLFE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fade engine assertion failed");

// Next-cycle implication, checked outside reset.
`define PLFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fade engine assertion failed");

`endif

// ===== src/plfe_pkg.sv =====
`default_nettype none
package plfe_pkg;
   localparam int COMP_W  = 8;
   localparam int ACC_W   = 16;
   localparam int DELTA_W = 17;
   localparam int TICK_W  = 9;

   // request codes
   localparam logic [2:0] REQ_WR_PAL = 3'd0;
   localparam logic [2:0] REQ_WR_TGT = 3'd1;
   localparam logic [2:0] REQ_START  = 3'd2;
   localparam logic [2:0] REQ_TICK   = 3'd3;
   localparam logic [2:0] REQ_READ   = 3'd4;
   localparam logic [2:0] REQ_ACK    = 3'd5;

   // register indexes
   localparam logic [1:0] CSR_FIRST  = 2'd0;
   localparam logic [1:0] CSR_LAST   = 2'd1;
   localparam logic [1:0] CSR_STEPS  = 2'd2;
   localparam logic [1:0] CSR_SHARED = 2'd3;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;
endpackage
`default_nettype wire

// ===== src/plfe_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle, truncates toward zero.
module plfe_div import plfe_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [DELTA_W-1:0] dividend,
   input  logic [COMP_W-1:0]         divisor,
   output div_status_type            status,
   output logic signed [DELTA_W-1:0] quotient
);
   localparam int MAG_W = DELTA_W - 1;

   logic              busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [MAG_W-1:0]  mq_ff, mq_in;
   logic [COMP_W-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [COMP_W:0]   trial, trial_sub;
   logic              ge;
   logic signed [DELTA_W-1:0] mag;

   always_comb begin
      mag       = dividend[DELTA_W-1] ? -dividend : dividend;
      trial     = {rem_ff, mq_ff[MAG_W-1]};
      ge        = trial >= {1'b0, dvs_ff};
      trial_sub = trial - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      mq_in   = mq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[DELTA_W-1];
         cnt_in  = '0;
         mq_in   = mag[MAG_W-1:0];
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? trial_sub[COMP_W-1:0] : trial[COMP_W-1:0];
         mq_in  = {mq_ff[MAG_W-2:0], ge};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      mq_ff  <= mq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient = neg_ff ? -$signed({1'b0, mq_ff}) : $signed({1'b0, mq_ff});
endmodule
`default_nettype wire

// ===== src/palette_linear_fade_engine.sv =====
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_type, req_index, req_red/green/blue
// rsp       out        rsp_valid/rsp_ready  rsp_read_*, status, dirty range
// csr       in         csr_we               csr_index, csr_data
// Writes, reads and acknowledges go from ST_IDLE to ST_DONE; a read waits in ST_RDWAIT.
// A tick makes one memory read and one write-back per entry in range; a start runs
// the bit-serial divider once per entry, or makes an immediate copy of the target
// per entry when the step count is zero.
// Reset is synchronous; palette entries read as zero until written (valid bits).
// A new beat is taken once the previous one has moved to the output register.
`default_nettype none
module palette_linear_fade_engine import plfe_pkg::*; #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_type,
   input  logic [7:0]          req_index,
   input  logic [COMP_W-1:0]   req_red,
   input  logic [COMP_W-1:0]   req_green,
   input  logic [COMP_W-1:0]   req_blue,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [COMP_W-1:0]   rsp_read_red,
   output logic [COMP_W-1:0]   rsp_read_green,
   output logic [COMP_W-1:0]   rsp_read_blue,
   output logic                rsp_fade_running,
   output logic                rsp_palette_changed,
   output logic [7:0]          rsp_changed_low,
   output logic [7:0]          rsp_changed_high,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_data
);
`include "palette_linear_fade_engine_defines.svh"

   localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam logic [8:0] DEPTH9 = 9'(PALETTE_DEPTH);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_RDWAIT = 4'd1;
   localparam logic [3:0] ST_S_RD   = 4'd2;
   localparam logic [3:0] ST_S_WAIT = 4'd3;
   localparam logic [3:0] ST_S_DIV  = 4'd4;
   localparam logic [3:0] ST_S_END  = 4'd5;
   localparam logic [3:0] ST_T_RD   = 4'd6;
   localparam logic [3:0] ST_T_UPD  = 4'd7;
   localparam logic [3:0] ST_T_END  = 4'd8;
   localparam logic [3:0] ST_DONE   = 4'd9;

   // memories
   logic [3*COMP_W-1:0]  pal_mem [PALETTE_DEPTH];
   logic [3*COMP_W-1:0]  tgt_mem [256];
   logic [3*ACC_W-1:0]   acc_mem [PALETTE_DEPTH];
   logic [3*DELTA_W-1:0] dlt_mem [PALETTE_DEPTH];
   logic [3*COMP_W-1:0]  pal_q, tgt_q;
   logic [3*ACC_W-1:0]   acc_q;
   logic [3*DELTA_W-1:0] dlt_q;

   logic                 pal_we, pal_re, tgt_we, tgt_re, acc_we, acc_re, dlt_we;
   logic [AW-1:0]        pal_wa, pal_ra, acc_wa, dlt_wa, walk_a;
   logic [7:0]           tgt_wa, tgt_ra;
   logic [3*COMP_W-1:0]  pal_wd, tgt_wd;
   logic [3*ACC_W-1:0]   acc_wd;
   logic [3*DELTA_W-1:0] dlt_wd;

   // control and state
   logic [3:0]        state_ff, state_in;
   logic [7:0]        first_ff, first_in, last_ff, last_in, steps_ff, steps_in;
   logic              shared_ff, shared_in;
   logic [7:0]        ffirst_ff, ffirst_in, flast_ff, flast_in, fsteps_ff, fsteps_in;
   logic              fshared_ff, fshared_in;
   logic [TICK_W-1:0] ticks_ff, ticks_in, ticks_dec;
   logic              fade_on_ff, fade_on_in, chg_ff, chg_in;
   logic [7:0]        dlow_ff, dlow_in, dhigh_ff, dhigh_in;
   logic [7:0]        ci_ff, ci_in, ti_ff, ti_in, idx_ff, idx_in;
   logic [PALETTE_DEPTH-1:0] pvalid_ff, pvalid_in;
   logic [3*COMP_W-1:0] rd_ff, rd_in, pal_cur;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [3*COMP_W-1:0] orgb_ff, orgb_in;
   logic              orun_ff, orun_in, ochg_ff, ochg_in;
   logic [7:0]        olow_ff, olow_in, ohigh_ff, ohigh_in;
   logic              ci_in_range, idx_in_range, at_last, req_fire;

   // dividers, one lane per component
   logic                      div_start;
   logic signed [DELTA_W-1:0] div_num [3];
   logic signed [DELTA_W-1:0] div_q   [3];
   div_status_type            div_st  [3];

   for (genvar c = 0; c < 3; c++) begin : g_div
      plfe_div u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (div_start),
         .dividend (div_num[c]),
         .divisor  (fsteps_ff),
         .status   (div_st[c]),
         .quotient (div_q[c])
      );
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign req_fire     = req_valid && req_ready;
   assign ci_in_range  = {1'b0, ci_ff} < DEPTH9;
   assign idx_in_range = {1'b0, req_index} < DEPTH9;
   assign at_last      = (ci_ff == flast_ff);
   assign walk_a       = ci_ff[AW-1:0];
   assign ticks_dec    = ticks_ff - TICK_W'(1);
   assign pal_cur      = pvalid_ff[walk_a] ? pal_q : '0;

   // dividends: target*256 - palette*256 per component
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         div_num[c] = $signed({1'b0, tgt_q[c*COMP_W +: COMP_W], 8'h00})
                    - $signed({1'b0, pal_cur[c*COMP_W +: COMP_W], 8'h00});
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      first_in   = first_ff;
      last_in    = last_ff;
      steps_in   = steps_ff;
      shared_in  = shared_ff;
      ffirst_in  = ffirst_ff;
      flast_in   = flast_ff;
      fsteps_in  = fsteps_ff;
      fshared_in = fshared_ff;
      ticks_in   = ticks_ff;
      fade_on_in = fade_on_ff;
      chg_in     = chg_ff;
      dlow_in    = dlow_ff;
      dhigh_in   = dhigh_ff;
      ci_in      = ci_ff;
      ti_in      = ti_ff;
      idx_in     = idx_ff;
      pvalid_in  = pvalid_ff;
      rd_in      = rd_ff;
      pal_we = 1'b0; pal_wa = walk_a; pal_wd = tgt_q;
      pal_re = 1'b0; pal_ra = walk_a;
      tgt_we = 1'b0; tgt_wa = req_index; tgt_wd = {req_red, req_green, req_blue};
      tgt_re = 1'b0; tgt_ra = ti_ff;
      acc_we = 1'b0; acc_wa = walk_a; acc_wd = '0;
      acc_re = 1'b0;
      dlt_we = 1'b0; dlt_wa = walk_a;
      dlt_wd = {div_q[2], div_q[1], div_q[0]};
      div_start = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      orgb_in  = orgb_ff;
      orun_in  = orun_ff;
      ochg_in  = ochg_ff;
      olow_in  = olow_ff;
      ohigh_in = ohigh_ff;

      // register writes must arrive only while idle; the block does not enforce this
      if (csr_we) begin
         unique case (csr_index)
            CSR_FIRST:  first_in  = csr_data;
            CSR_LAST:   last_in   = csr_data;
            CSR_STEPS:  steps_in  = csr_data;
            CSR_SHARED: shared_in = csr_data[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               idx_in   = req_index;
               rd_in    = '0;
               state_in = ST_DONE;
               unique case (req_type)
                  REQ_WR_PAL: begin
                     if (idx_in_range) begin
                        pal_we = 1'b1;
                        pal_wa = req_index[AW-1:0];
                        pal_wd = {req_red, req_green, req_blue};
                        pvalid_in[req_index[AW-1:0]] = 1'b1;
                        chg_in = 1'b1;
                        if (dlow_ff > req_index) dlow_in = req_index;
                        if (dhigh_ff < req_index) dhigh_in = req_index;
                     end
                  end
                  REQ_WR_TGT: tgt_we = 1'b1;
                  REQ_START: begin
                     fade_on_in = 1'b0;
                     ffirst_in  = first_ff;
                     flast_in   = last_ff;
                     fsteps_in  = steps_ff;
                     fshared_in = shared_ff;
                     ticks_in   = {1'b0, steps_ff} + TICK_W'(1);
                     ci_in      = first_ff;
                     ti_in      = '0;
                     state_in   = (first_ff <= last_ff) ? ST_S_RD : ST_S_END;
                  end
                  REQ_TICK: begin
                     if (fade_on_ff) begin
                        ticks_in = ticks_dec;
                        ci_in    = ffirst_ff;
                        if (ticks_dec == '0) begin
                           fade_on_in = 1'b0;
                        end else begin
                           state_in = (ffirst_ff <= flast_ff) ? ST_T_RD : ST_T_END;
                        end
                     end
                  end
                  REQ_READ: begin
                     pal_re   = 1'b1;
                     pal_ra   = req_index[AW-1:0];
                     state_in = ST_RDWAIT;
                  end
                  REQ_ACK: chg_in = 1'b0;
                  default: ;
               endcase
            end
         end
         ST_RDWAIT: begin
            if ({1'b0, idx_ff} < DEPTH9 && pvalid_ff[idx_ff[AW-1:0]]) rd_in = pal_q;
            state_in = ST_DONE;
         end
         ST_S_RD: begin
            if (ci_in_range) begin
               pal_re   = 1'b1;
               tgt_re   = 1'b1;
               state_in = ST_S_WAIT;
            end else if (at_last) begin
               state_in = ST_S_END;
            end else begin
               ci_in = ci_ff + 8'd1;
               ti_in = ti_ff + {7'd0, !fshared_ff};
            end
         end
         ST_S_WAIT: begin
            if (fsteps_ff == '0) begin
               // immediate copy of the target
               pal_we = 1'b1;
               pal_wd = tgt_q;
               pvalid_in[walk_a] = 1'b1;
               state_in = at_last ? ST_S_END : ST_S_RD;
               ci_in = ci_ff + 8'd1;
               ti_in = ti_ff + {7'd0, !fshared_ff};
            end else begin
               acc_we = 1'b1;
               acc_wd = {pal_cur[23:16], 8'h00, pal_cur[15:8], 8'h00,
                         pal_cur[7:0], 8'h00};
               div_start = 1'b1;
               state_in  = ST_S_DIV;
            end
         end
         ST_S_DIV: begin
            if (div_st[0].done) begin
               dlt_we   = 1'b1;
               state_in = at_last ? ST_S_END : ST_S_RD;
               ci_in = ci_ff + 8'd1;
               ti_in = ti_ff + {7'd0, !fshared_ff};
            end
         end
         ST_S_END: begin
            if (fsteps_ff == '0) begin
               chg_in = 1'b1;
               if (dlow_ff > ffirst_ff) dlow_in = ffirst_ff;
               if (dhigh_ff < flast_ff) dhigh_in = flast_ff;
            end else begin
               fade_on_in = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_T_RD: begin
            if (ci_in_range) begin
               acc_re   = 1'b1;
               state_in = ST_T_UPD;
            end else if (at_last) begin
               state_in = ST_T_END;
            end else begin
               ci_in = ci_ff + 8'd1;
            end
         end
         ST_T_UPD: begin
            // add the step and write back the top bytes
            for (int c = 0; c < 3; c++) begin
               acc_wd[c*ACC_W +: ACC_W] = acc_q[c*ACC_W +: ACC_W]
                                        + dlt_q[c*DELTA_W +: ACC_W];
               pal_wd[c*COMP_W +: COMP_W] = acc_wd[c*ACC_W + COMP_W +: COMP_W];
            end
            acc_we = 1'b1;
            pal_we = 1'b1;
            pvalid_in[walk_a] = 1'b1;
            state_in = at_last ? ST_T_END : ST_T_RD;
            ci_in = ci_ff + 8'd1;
         end
         ST_T_END: begin
            chg_in = 1'b1;
            if (dlow_ff > ffirst_ff) dlow_in = ffirst_ff;
            if (dhigh_ff < flast_ff) dhigh_in = flast_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               orgb_in  = rd_ff;
               orun_in  = fade_on_ff;
               ochg_in  = chg_ff;
               olow_in  = dlow_ff;
               ohigh_in = dhigh_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (pal_we) pal_mem[pal_wa] <= pal_wd;
      if (pal_re) pal_q <= pal_mem[pal_ra];
      if (tgt_we) tgt_mem[tgt_wa] <= tgt_wd;
      if (tgt_re) tgt_q <= tgt_mem[tgt_ra];
      if (acc_we) acc_mem[acc_wa] <= acc_wd;
      if (acc_re) acc_q <= acc_mem[walk_a];
      if (dlt_we) dlt_mem[dlt_wa] <= dlt_wd;
      if (acc_re) dlt_q <= dlt_mem[walk_a];
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_ff     <= '0;
         last_ff      <= '0;
         steps_ff     <= '0;
         shared_ff    <= 1'b0;
         ffirst_ff    <= '0;
         flast_ff     <= '0;
         fsteps_ff    <= '0;
         fshared_ff   <= 1'b0;
         ticks_ff     <= TICK_W'(1);
         fade_on_ff   <= 1'b0;
         chg_ff       <= 1'b0;
         dlow_ff      <= '0;
         dhigh_ff     <= '0;
         pvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         steps_ff     <= steps_in;
         shared_ff    <= shared_in;
         ffirst_ff    <= ffirst_in;
         flast_ff     <= flast_in;
         fsteps_ff    <= fsteps_in;
         fshared_ff   <= fshared_in;
         ticks_ff     <= ticks_in;
         fade_on_ff   <= fade_on_in;
         chg_ff       <= chg_in;
         dlow_ff      <= dlow_in;
         dhigh_ff     <= dhigh_in;
         pvalid_ff    <= pvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ci_ff    <= ci_in;
      ti_ff    <= ti_in;
      idx_ff   <= idx_in;
      rd_ff    <= rd_in;
      orgb_ff  <= orgb_in;
      orun_ff  <= orun_in;
      ochg_ff  <= ochg_in;
      olow_ff  <= olow_in;
      ohigh_ff <= ohigh_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_red        = orgb_ff[23:16];
   assign rsp_read_green      = orgb_ff[15:8];
   assign rsp_read_blue       = orgb_ff[7:0];
   assign rsp_fade_running    = orun_ff;
   assign rsp_palette_changed = ochg_ff;
   assign rsp_changed_low     = olow_ff;
   assign rsp_changed_high    = ohigh_ff;

   // checks
   `PLFE_ASSERT_IMPL(a_idle_div_quiet, clock, reset, req_fire, !div_st[0].busy)
   `PLFE_ASSERT_IMPL(a_fade_ticks, clock, reset, fade_on_ff, ticks_ff != '0)
   `PLFE_ASSERT_NEXT(a_done_loads, clock, reset, (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready), rsp_valid_ff)
   `PLFE_ASSERT_IMPL(a_div_ends_in_div, clock, reset, div_st[0].done, state_ff == ST_S_DIV)
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb;
   import plfe_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // codes the block does not decode; they only report status
   localparam logic [2:0] REQ_SPARE6 = 3'd6;
   localparam logic [2:0] REQ_SPARE7 = 3'd7;
   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       running;
      logic       changed;
      logic [7:0] low;
      logic [7:0] high;
   } fade_status_type;

   // palette/fade predictor plus the queue of statuses still owed by the block
   class fade_scoreboard;
      logic [7:0]  pal [256][3];
      logic [7:0]  tgt [256][3];
      logic [15:0] acc [256][3];
      int          delta [256][3];
      logic [8:0]  ticks_left;
      logic        running, changed;
      logic [7:0]  dirty_lo, dirty_hi, fade_lo, fade_hi;
      logic [7:0]  first_col, last_col, steps;
      logic        shared;
      fade_status_type owed [$];
      int          errors;

      function new();
         foreach (pal[i, c]) begin
            pal[i][c] = '0;
            tgt[i][c] = '0;
            acc[i][c] = '0;
            delta[i][c] = 0;
         end
         ticks_left = 9'd1;
         running = 0;
         changed = 0;
         dirty_lo = '0;
         dirty_hi = '0;
         fade_lo = '0;
         fade_hi = '0;
         first_col = '0;
         last_col = '0;
         steps = '0;
         shared = 0;
         errors = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [7:0] data);
         case (idx)
            CSR_FIRST:  first_col = data;
            CSR_LAST:   last_col = data;
            CSR_STEPS:  steps = data;
            CSR_SHARED: shared = data[0];
            default: ;
         endcase
      endfunction

      function void widen(logic [7:0] lo, logic [7:0] hi);
         if (dirty_lo > lo) dirty_lo = lo;
         if (dirty_hi < hi) dirty_hi = hi;
         changed = 1;
      endfunction

      function void begin_fade();
         int t, diff;
         running = 0;
         fade_lo = first_col;
         fade_hi = last_col;
         ticks_left = {1'b0, steps} + 9'd1;
         t = 0;
         for (int i = fade_lo; i <= fade_hi; i++) begin
            for (int c = 0; c < 3; c++) begin
               if (steps == 0) begin
                  pal[i][c] = tgt[shared ? 0 : (t & 255)][c];
               end else begin
                  diff = int'(tgt[shared ? 0 : (t & 255)][c]) * 256 - int'(pal[i][c]) * 256;
                  acc[i][c] = {pal[i][c], 8'h00};
                  delta[i][c] = diff / int'(steps);
               end
            end
            t++;
         end
         if (steps == 0) widen(fade_lo, fade_hi);
         else running = 1;
      endfunction

      function void advance_fade();
         if (!running) return;
         ticks_left = ticks_left - 9'd1;
         if (ticks_left == 0) begin
            running = 0;
            return;
         end
         for (int i = fade_lo; i <= fade_hi; i++) begin
            for (int c = 0; c < 3; c++) begin
               acc[i][c] = acc[i][c] + delta[i][c][15:0];
               pal[i][c] = acc[i][c][15:8];
            end
         end
         widen(fade_lo, fade_hi);
      endfunction

      // accepted request beat: update the model and queue the status it yields
      function void note_request(logic [2:0] kind, logic [7:0] idx,
                                 logic [7:0] r, logic [7:0] g, logic [7:0] b);
         fade_status_type s;
         s = '0;
         case (kind)
            REQ_WR_PAL: begin
               pal[idx][0] = r;
               pal[idx][1] = g;
               pal[idx][2] = b;
               widen(idx, idx);
            end
            REQ_WR_TGT: begin
               tgt[idx][0] = r;
               tgt[idx][1] = g;
               tgt[idx][2] = b;
            end
            REQ_START: begin_fade();
            REQ_TICK:  advance_fade();
            REQ_READ: begin
               s.red = pal[idx][0];
               s.green = pal[idx][1];
               s.blue = pal[idx][2];
            end
            REQ_ACK: changed = 0;
            default: ;
         endcase
         s.running = running;
         s.changed = changed;
         s.low = dirty_lo;
         s.high = dirty_hi;
         owed.insert(owed.size(), s);
      endfunction

      function void check_response(fade_status_type got);
         fade_status_type exp;
         if (owed.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response beat %p", got);
            return;
         end
         exp = owed.pop_front();
         if (got.red !== exp.red || got.green !== exp.green || got.blue !== exp.blue ||
             got.running !== exp.running || got.changed !== exp.changed ||
             got.low !== exp.low || got.high !== exp.high) begin
            errors++;
            if (errors <= 10) $display("status mismatch: exp %p got %p", exp, got);
         end
      endfunction
   endclass

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_ready;
   logic [2:0] req_type = '0;
   logic [7:0] req_index = '0;
   logic [7:0] req_red = '0, req_green = '0, req_blue = '0;
   logic       rsp_valid;
   logic       rsp_ready = 0;
   logic [7:0] rsp_read_red, rsp_read_green, rsp_read_blue;
   logic       rsp_fade_running, rsp_palette_changed;
   logic [7:0] rsp_changed_low, rsp_changed_high;
   logic       csr_we = 0;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_data = '0;

   fade_scoreboard fades = new();
   bit hold_wanted = 0;
   bit hold_done = 0;
   int idle_cycles = 0;
   logic [7:0] rng_lo, rng_hi;

   palette_linear_fade_engine uut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // monitor: feed the predictor and check each response beat
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            fades.note_request(req_type, req_index, req_red, req_green, req_blue);
         if (rsp_valid && rsp_ready)
            fades.check_response({rsp_read_red, rsp_read_green, rsp_read_blue,
                                  rsp_fade_running, rsp_palette_changed,
                                  rsp_changed_low, rsp_changed_high});
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > STALL_LIMIT) begin
            $display("palette_linear_fade_engine: mismatch");
            $finish;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 9) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // receiver: ready stretches, short and long stalls, one long hold-off
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_wanted && !hold_done) begin
            rsp_ready <= 0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1;
         end else if ($urandom_range(0, 9) < 6) begin
            rsp_ready <= 1;
            repeat ($urandom_range(0, 40)) @(posedge clock);
         end else begin
            rsp_ready <= 0;
            repeat (pick_gap()) @(posedge clock);
         end
      end
   end

   task automatic send_beat(logic [2:0] kind, logic [7:0] idx,
                            logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_type <= kind;
      req_index <= idx;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // let every owed status come back, then idle for a margin
   task automatic drain();
      req_valid <= 0;
      do @(posedge clock); while (fades.owed.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [7:0] data);
      csr_we <= 1;
      csr_index <= idx;
      csr_data <= data;
      fades.set_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic configure(logic [7:0] first, logic [7:0] last, logic [7:0] steps,
                            logic shared);
      drain();
      csr_write(CSR_FIRST, first);
      csr_write(CSR_LAST, last);
      csr_write(CSR_STEPS, steps);
      csr_write(CSR_SHARED, {7'd0, shared});
      csr_we <= 0;
      rng_lo = first;
      rng_hi = last;
   endtask

   // mostly ticks and traffic near the fade range, with the odd spare code
   task automatic random_beat();
      int r;
      logic [2:0] kind;
      logic [7:0] idx;
      r = $urandom_range(0, 99);
      if (r < 35) kind = REQ_TICK;
      else if (r < 53) kind = REQ_WR_PAL;
      else if (r < 73) kind = REQ_READ;
      else if (r < 80) kind = REQ_START;
      else if (r < 88) kind = REQ_WR_TGT;
      else if (r < 96) kind = REQ_ACK;
      else kind = $urandom_range(0, 1) ? REQ_SPARE6 : REQ_SPARE7;
      if ($urandom_range(0, 2) != 0 && rng_lo <= rng_hi)
         idx = 8'($urandom_range(rng_lo, rng_hi));
      else
         idx = 8'($urandom_range(0, 255));
      send_beat(kind, idx, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   initial begin
      int n_items;
      logic [7:0] f;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // every target entry gets written before any fade can read it
      for (int i = 0; i < 256; i++)
         send_beat(REQ_WR_TGT, i[7:0], 8'($urandom), 8'($urandom), 8'($urandom));

      // directed: extremes, idle tick, spare codes, immediate copy of everything
      send_beat(REQ_READ, 8'd128, 8'hFF, 8'hFF, 8'hFF);
      send_beat(REQ_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
      send_beat(REQ_WR_PAL, 8'd255, 8'hFF, 8'hFF, 8'hFF);
      send_beat(REQ_WR_PAL, 8'd0, 8'h00, 8'h00, 8'h00);
      send_beat(REQ_READ, 8'd255, 8'd0, 8'd0, 8'd0);
      send_beat(REQ_ACK, 8'd0, 8'd0, 8'd0, 8'd0);
      send_beat(REQ_SPARE6, 8'd7, 8'd1, 8'd2, 8'd3);
      send_beat(REQ_SPARE7, 8'd9, 8'd4, 8'd5, 8'd6);
      configure(8'd0, 8'd255, 8'd0, 1'b0);
      send_beat(REQ_START, 8'd0, 8'd0, 8'd0, 8'd0);
      send_beat(REQ_READ, 8'd200, 8'd0, 8'd0, 8'd0);
      // empty range: copy marks dirty but updates nothing
      configure(8'd40, 8'd30, 8'd0, 1'b0);
      send_beat(REQ_ACK, 8'd0, 8'd0, 8'd0, 8'd0);
      send_beat(REQ_START, 8'd0, 8'd0, 8'd0, 8'd0);
      // one-step fade, shared target, to the last tick and past it
      configure(8'd250, 8'd255, 8'd1, 1'b1);
      send_beat(REQ_START, 8'd0, 8'd0, 8'd0, 8'd0);
      repeat (3) send_beat(REQ_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
      send_beat(REQ_READ, 8'd252, 8'd0, 8'd0, 8'd0);
      // restart while running
      configure(8'd100, 8'd103, 8'd255, 1'b0);
      send_beat(REQ_START, 8'd0, 8'd0, 8'd0, 8'd0);
      send_beat(REQ_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
      send_beat(REQ_START, 8'd0, 8'd0, 8'd0, 8'd0);
      send_beat(REQ_TICK, 8'd0, 8'd0, 8'd0, 8'd0);

      // random phases; the first two are short and span the whole palette, the rest are mostly narrow
      for (int p = 0; p < 14; p++) begin
         n_items = 135;
         if (p == 0) begin
            configure(8'd0, 8'd255, 8'd3, 1'b1);
            n_items = 12;
         end else if (p == 1) begin
            configure(8'd0, 8'd255, 8'd255, 1'b0);
            n_items = 12;
         end else begin
            f = 8'($urandom);
            configure(f, ($urandom_range(0, 9) == 0) ? f - 8'd1
                         : ((f > 8'd240) ? 8'd255 : f + 8'($urandom_range(0, 15))),
                      ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 6)),
                      1'($urandom_range(0, 1)));
         end
         if (p == 5) hold_wanted = 1;
         for (int k = 0; k < n_items; k++) begin
            if (k % 40 == 0)
               send_beat(REQ_START, 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom));
            else random_beat();
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (fades.owed.size() != 0) fades.errors++;
      if (fades.errors == 0) begin
         $display("palette_linear_fade_engine: match");
      end else begin
         $display("palette_linear_fade_engine: mismatch");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== palette_linear_fade_engine.f =====
+incdir+src
src/plfe_pkg.sv
src/plfe_div.sv
src/palette_linear_fade_engine.sv
tb/tb.sv
